// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`define RFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define RFA_ASSERT_NEXT(lbl, ante, cons)
`define RFA_ASSERT_NOW(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/rfa_pkg.sv =====
// shared types and constants of the restricted factor argmin core
package rfa_pkg;

    localparam int DEF_MAX_VARS   = 4;
    localparam int DEF_LABEL_BITS = 8;
    localparam int DEF_COST_BITS  = 32;

    localparam int NUM_OUT_LABELS = 4;
    localparam int NUM_VARS_W     = 3;
    localparam int PACKED_W       = 32;
    localparam int FIXED_MASK_W   = 4;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [NUM_VARS_W-1:0]   RST_NUM_VARS     = 3'd2;
    localparam logic [PACKED_W-1:0]     RST_LABEL_COUNTS = 32'h0202_0202;
    localparam logic [FIXED_MASK_W-1:0] RST_FIXED_MASK   = 4'h0;
    localparam logic [PACKED_W-1:0]     RST_FIXED_LABELS = 32'h0000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_VARS     = 2'd0,
        CFG_LABEL_COUNTS = 2'd1,
        CFG_FIXED_MASK   = 2'd2,
        CFG_FIXED_LABELS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [NUM_VARS_W-1:0]   num_vars;
        logic [PACKED_W-1:0]     label_counts;
        logic [FIXED_MASK_W-1:0] fixed_mask;
        logic [PACKED_W-1:0]     fixed_labels;
    } cfg_t;

    typedef struct packed {
        logic adv;
        logic last;
    } step_t;

endpackage

// ===== hw/rtl/rfa_digit_counter.sv =====
// mixed-radix digit counter with fixed-label match test
module rfa_digit_counter #(
    parameter int MAX_VARS   = rfa_pkg::DEF_MAX_VARS,
    parameter int LABEL_BITS = rfa_pkg::DEF_LABEL_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rfa_pkg::cfg_t                        cfg,
    input  rfa_pkg::step_t                       step,
    output logic [MAX_VARS-1:0][LABEL_BITS-1:0]  labels,
    output logic                                 match
);

    logic [MAX_VARS-1:0][LABEL_BITS-1:0] digit_reg;
    logic [MAX_VARS-1:0][LABEL_BITS-1:0] digit_next;
    logic [MAX_VARS-1:0]                 var_en;

    always_comb begin
        logic [rfa_pkg::FIXED_MASK_W-1:0] fm_sh;
        logic [rfa_pkg::PACKED_W-1:0]     fl_sh;
        match = 1'b1;
        for (int d = 0; d < MAX_VARS; d++) begin
            if (cfg.num_vars == '0) begin
                var_en[d] = (d == 0);
            end else begin
                var_en[d] = ({1'b0, cfg.num_vars} > 4'(d));
            end
            fm_sh = cfg.fixed_mask >> d;
            fl_sh = cfg.fixed_labels >> (d * LABEL_BITS);
            labels[d] = var_en[d] ? digit_reg[d] : '0;
            if (var_en[d] && fm_sh[0] && (digit_reg[d] != fl_sh[LABEL_BITS-1:0])) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        logic                         carry;
        logic [rfa_pkg::PACKED_W-1:0] lc_sh;
        logic [LABEL_BITS:0]          inc;
        carry      = 1'b1;
        digit_next = digit_reg;
        for (int d = MAX_VARS - 1; d >= 0; d--) begin
            lc_sh = cfg.label_counts >> (d * LABEL_BITS);
            inc   = {1'b0, digit_reg[d]} + 1'b1;
            if (var_en[d] && carry) begin
                if (lc_sh[LABEL_BITS-1:0] == '0) begin
                    digit_next[d] = inc[LABEL_BITS-1:0];
                    carry         = inc[LABEL_BITS];
                end else if (inc < {1'b0, lc_sh[LABEL_BITS-1:0]}) begin
                    digit_next[d] = inc[LABEL_BITS-1:0];
                    carry         = 1'b0;
                end else begin
                    digit_next[d] = '0;
                    carry         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else if (step.adv) begin
            digit_reg <= step.last ? '0 : digit_next;
        end
    end

endmodule

// ===== hw/rtl/rfa_best_tracker.sv =====
// running first strict minimum over matching entries
module rfa_best_tracker #(
    parameter int MAX_VARS   = rfa_pkg::DEF_MAX_VARS,
    parameter int LABEL_BITS = rfa_pkg::DEF_LABEL_BITS,
    parameter int COST_BITS  = rfa_pkg::DEF_COST_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rfa_pkg::step_t                       step,
    input  logic                                 match,
    input  logic signed [COST_BITS-1:0]          cost,
    input  logic [MAX_VARS-1:0][LABEL_BITS-1:0]  labels,
    output logic [MAX_VARS-1:0][LABEL_BITS-1:0]  res_labels,
    output logic signed [COST_BITS-1:0]          res_cost,
    output logic                                 res_no_match,
    output logic                                 have_best
);

    logic                                have_best_reg;
    logic signed [COST_BITS-1:0]         best_cost_reg;
    logic [MAX_VARS-1:0][LABEL_BITS-1:0] best_labels_reg;
    logic                                take;

    assign have_best    = have_best_reg;
    assign take         = match && (!have_best_reg || (cost < best_cost_reg));
    assign res_cost     = take ? cost : (have_best_reg ? best_cost_reg : '0);
    assign res_labels   = take ? labels : (have_best_reg ? best_labels_reg : '0);
    assign res_no_match = !(have_best_reg || take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
        end else if (step.adv) begin
            have_best_reg <= step.last ? 1'b0 : (have_best_reg || take);
        end
    end

    always_ff @(posedge aclk) begin
        if (step.adv && take) begin
            best_cost_reg   <= cost;
            best_labels_reg <= labels;
        end
    end

endmodule

// ===== hw/rtl/restricted_factor_argmin_core.sv =====
// top level of the restricted factor argmin core
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: cost; tlast: last table entry
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: labels, min_cost; tuser: no_match
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one table entry per cycle unless a last entry waits; digit counter and best-cost compare advance with each entry
// result is registered once the last entry leaves the input register, held until m_axis_tready
// a last entry waits in the input register only while an older result is not yet taken
// synchronous active-low reset clears counter, have-best flag and both valid flags, and loads the reset config
`include "assert_macros.svh"

module restricted_factor_argmin_core #(
    parameter int MAX_VARS   = rfa_pkg::DEF_MAX_VARS,
    parameter int LABEL_BITS = rfa_pkg::DEF_LABEL_BITS,
    parameter int COST_BITS  = rfa_pkg::DEF_COST_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // cost [COST_BITS-1:0], zero pad
    input  logic [((COST_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic                                s_axis_tlast,
    // label_0, label_1, label_2, label_3, min_cost, zero pad
    output logic [((rfa_pkg::NUM_OUT_LABELS*LABEL_BITS+COST_BITS+7)/8)*8-1:0] m_axis_tdata,
    // no_match
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfa_pkg::PACKED_W-1:0]        cfg_data
);

    localparam int OUT_LAB_W = rfa_pkg::NUM_OUT_LABELS * LABEL_BITS;
    localparam int OUT_W     = ((OUT_LAB_W + COST_BITS + 7) / 8) * 8;

    rfa_pkg::cfg_t cfg_reg;

    logic                        in_vld_reg;
    logic                        in_last_reg;
    logic signed [COST_BITS-1:0] in_cost_reg;

    logic                        out_vld_reg;
    logic [OUT_LAB_W-1:0]        out_lab_reg;
    logic [OUT_LAB_W-1:0]        out_lab_next;
    logic [COST_BITS-1:0]        out_cost_reg;
    logic                        out_nm_reg;

    rfa_pkg::step_t                      step;
    logic [MAX_VARS-1:0][LABEL_BITS-1:0] cur_labels;
    logic [MAX_VARS-1:0][LABEL_BITS-1:0] res_labels;
    logic signed [COST_BITS-1:0]         res_cost;
    logic                                res_no_match;
    logic                                match;
    logic                                have_best;

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_vars     <= rfa_pkg::RST_NUM_VARS;
            cfg_reg.label_counts <= rfa_pkg::RST_LABEL_COUNTS;
            cfg_reg.fixed_mask   <= rfa_pkg::RST_FIXED_MASK;
            cfg_reg.fixed_labels <= rfa_pkg::RST_FIXED_LABELS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (rfa_pkg::cfg_idx_t'(cfg_index))
                rfa_pkg::CFG_NUM_VARS: begin
                    cfg_reg.num_vars <= cfg_data[rfa_pkg::NUM_VARS_W-1:0];
                end
                rfa_pkg::CFG_LABEL_COUNTS: begin
                    cfg_reg.label_counts <= cfg_data;
                end
                rfa_pkg::CFG_FIXED_MASK: begin
                    cfg_reg.fixed_mask <= cfg_data[rfa_pkg::FIXED_MASK_W-1:0];
                end
                rfa_pkg::CFG_FIXED_LABELS: begin
                    cfg_reg.fixed_labels <= cfg_data;
                end
            endcase
        end
    end

    // input register
    assign step.adv  = in_vld_reg && !(in_last_reg && out_vld_reg && !m_axis_tready);
    assign step.last = in_last_reg;
    assign s_axis_tready = !in_vld_reg || step.adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cost_reg <= s_axis_tdata[COST_BITS-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    rfa_digit_counter #(
        .MAX_VARS   (MAX_VARS),
        .LABEL_BITS (LABEL_BITS)
    ) u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .labels  (cur_labels),
        .match   (match)
    );

    rfa_best_tracker #(
        .MAX_VARS   (MAX_VARS),
        .LABEL_BITS (LABEL_BITS),
        .COST_BITS  (COST_BITS)
    ) u_best (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .match        (match),
        .cost         (in_cost_reg),
        .labels       (cur_labels),
        .res_labels   (res_labels),
        .res_cost     (res_cost),
        .res_no_match (res_no_match),
        .have_best    (have_best)
    );

    // result register
    for (genvar v = 0; v < rfa_pkg::NUM_OUT_LABELS; v++) begin : g_out_lab
        if (v < MAX_VARS) begin : g_used
            assign out_lab_next[v*LABEL_BITS +: LABEL_BITS] = res_labels[v];
        end else begin : g_unused
            assign out_lab_next[v*LABEL_BITS +: LABEL_BITS] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step.adv && step.last) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.adv && step.last) begin
            out_lab_reg  <= out_lab_next;
            out_cost_reg <= res_cost;
            out_nm_reg   <= res_no_match;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_W'({out_cost_reg, out_lab_reg});
    assign m_axis_tuser  = out_nm_reg;

    // checks
    `RFA_ASSERT_NEXT(a_last_gives_result, step.adv && step.last, m_axis_tvalid)
    `RFA_ASSERT_NEXT(a_last_clears_best, step.adv && step.last, !have_best)
    `RFA_ASSERT_NOW(a_no_match_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `RFA_ASSERT_NOW(a_stall_only_last, in_vld_reg && !s_axis_tready, in_last_reg && out_vld_reg)

endmodule

// ===== sim/argmin_checker.sv =====
// checker for the restricted factor argmin core: predicts and compares every result
`timescale 1ns / 100ps

module argmin_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    localparam int MAX_VARS = rfa_pkg::DEF_MAX_VARS;

    typedef struct packed {
        logic [3:0][7:0] lab;
        logic [31:0]     cost;
        logic            no_match;
    } argmin_t;

    logic [rfa_pkg::NUM_VARS_W-1:0]   num_vars     = rfa_pkg::RST_NUM_VARS;
    logic [rfa_pkg::PACKED_W-1:0]     label_counts = rfa_pkg::RST_LABEL_COUNTS;
    logic [rfa_pkg::FIXED_MASK_W-1:0] fixed_mask   = rfa_pkg::RST_FIXED_MASK;
    logic [rfa_pkg::PACKED_W-1:0]     fixed_labels = rfa_pkg::RST_FIXED_LABELS;

    logic [7:0]        digit [MAX_VARS];
    logic signed [31:0] best_cost;
    logic [7:0]        best_lab [MAX_VARS];
    logic              have_best;

    argmin_t expected_argmins [$];

    function automatic void clear_table();
        for (int v = 0; v < MAX_VARS; v++) begin
            digit[v]    = 8'd0;
            best_lab[v] = 8'd0;
        end
        best_cost = 32'sd0;
        have_best = 1'b0;
    endfunction

    function automatic void fold_entry(input logic [31:0] cost, input logic last);
        int n;
        logic hit;
        logic carry;
        logic [7:0] cnt;
        argmin_t res;
        n = (num_vars == 0) ? 1 : ((num_vars > MAX_VARS) ? MAX_VARS : int'(num_vars));
        hit = 1'b1;
        for (int v = 0; v < n; v++)
            if (fixed_mask[v] && digit[v] != fixed_labels[8*v +: 8])
                hit = 1'b0;
        if (hit && (!have_best || $signed(cost) < best_cost)) begin
            best_cost = $signed(cost);
            have_best = 1'b1;
            for (int v = 0; v < MAX_VARS; v++)
                best_lab[v] = (v < n) ? digit[v] : 8'd0;
        end
        // mixed-radix increment, last variable fastest
        carry = 1'b1;
        for (int v = n - 1; v >= 0; v--) begin
            if (carry) begin
                cnt = label_counts[8*v +: 8];
                if (cnt == 8'd0) begin
                    digit[v] = digit[v] + 8'd1;
                    carry = (digit[v] == 8'd0);
                end else if ({1'b0, digit[v]} + 9'd1 < {1'b0, cnt}) begin
                    digit[v] = digit[v] + 8'd1;
                    carry = 1'b0;
                end else begin
                    digit[v] = 8'd0;
                end
            end
        end
        if (last) begin
            for (int v = 0; v < 4; v++)
                res.lab[v] = have_best ? best_lab[v] : 8'd0;
            res.cost     = have_best ? best_cost : 32'd0;
            res.no_match = !have_best;
            expected_argmins.push_back(res);
            clear_table();
        end
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        argmin_t want;
        if (!aresetn) begin
            num_vars     = rfa_pkg::RST_NUM_VARS;
            label_counts = rfa_pkg::RST_LABEL_COUNTS;
            fixed_mask   = rfa_pkg::RST_FIXED_MASK;
            fixed_labels = rfa_pkg::RST_FIXED_LABELS;
            clear_table();
            expected_argmins.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (rfa_pkg::cfg_idx_t'(cfg_index))
                    rfa_pkg::CFG_NUM_VARS:     num_vars = cfg_data[rfa_pkg::NUM_VARS_W-1:0];
                    rfa_pkg::CFG_LABEL_COUNTS: label_counts = cfg_data;
                    rfa_pkg::CFG_FIXED_MASK:
                        fixed_mask = cfg_data[rfa_pkg::FIXED_MASK_W-1:0];
                    rfa_pkg::CFG_FIXED_LABELS: fixed_labels = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_argmins.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = expected_argmins.pop_front();
                    for (int v = 0; v < 4; v++)
                        compare_field($sformatf("label_%0d", v), want.lab[v],
                                      m_axis_tdata[8*v +: 8]);
                    compare_field("min_cost", want.cost, m_axis_tdata[32 +: 32]);
                    compare_field("no_match", want.no_match, m_axis_tuser);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                fold_entry(s_axis_tdata, s_axis_tlast);
        end
        outstanding = expected_argmins.size();
    end

endmodule

// ===== sim/tb_restricted_factor_argmin_core.sv =====
// testbench top for the restricted factor argmin core: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_restricted_factor_argmin_core;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic        s_axis_tlast  = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    rfa_pkg::cfg_idx_t cfg_index = rfa_pkg::CFG_NUM_VARS;
    logic [31:0] cfg_data      = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    restricted_factor_argmin_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    argmin_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    initial begin
        #2_000_000;
        $display("restricted_factor_argmin_core test failed");
        $finish;
    end

    task automatic put_entry(input logic [31:0] cost, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cost;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // wait until every result is taken, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_regs(input logic [2:0] nv, input logic [31:0] counts,
                             input logic [3:0] mask, input logic [31:0] fixl);
        logic [31:0] vals [4];
        vals[rfa_pkg::CFG_NUM_VARS]     = {$urandom} & ~32'h7 | {29'd0, nv};
        vals[rfa_pkg::CFG_LABEL_COUNTS] = counts;
        vals[rfa_pkg::CFG_FIXED_MASK]   = {$urandom} & ~32'hF | {28'd0, mask};
        vals[rfa_pkg::CFG_FIXED_LABELS] = fixl;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= rfa_pkg::cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_cost();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3, 4: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_table(input int unsigned len);
        for (int unsigned k = 1; k <= len; k++)
            put_entry(pick_cost(), k == len);
    endtask

    initial begin
        logic [2:0]  nv;
        logic [31:0] counts;
        logic [3:0]  mask;
        logic [31:0] fixl;
        logic [7:0]  c;
        int unsigned en;
        int unsigned prod;
        int unsigned len;
        int unsigned sent;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: two variables of two labels, extremes and a tie
        put_entry(32'h7FFF_FFFF, 1'b0);
        put_entry(32'h8000_0000, 1'b0);
        put_entry(32'h8000_0000, 1'b0);
        put_entry(32'h0000_0000, 1'b1);
        put_entry(32'hFFFF_FFFF, 1'b1);
        // longer than the table, the counter wraps
        put_entry(32'd9, 1'b0);
        put_entry(32'd8, 1'b0);
        put_entry(32'd7, 1'b0);
        put_entry(32'd6, 1'b0);
        put_entry(32'd5, 1'b0);
        put_entry(32'd4, 1'b1);
        settle();

        // zero variables, zero label count, mask bits above the variable count
        load_regs(3'd0, 32'h0000_0000, 4'hE, 32'hFFFF_FFFF);
        put_entry(32'd3, 1'b0);
        put_entry(32'd2, 1'b0);
        put_entry(32'd2, 1'b1);
        settle();

        // fixed label not below its count: nothing matches
        load_regs(3'd3, 32'hFF02_0202, 4'h1, 32'h0000_0002);
        put_entry(32'd1, 1'b0);
        put_entry(32'hFFFF_FFFB, 1'b1);
        settle();

        // variable count above the maximum, every variable fixed
        load_regs(3'd7, 32'h0101_0101, 4'hF, 32'h0000_0000);
        put_entry(32'd4, 1'b0);
        put_entry(32'hFFFF_FFFC, 1'b0);
        put_entry(32'd100, 1'b1);
        settle();

        for (int p = 0; p < 14; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            nv = 3'($urandom_range(0, 7));
            if (p == 0 || p == 2 || p == 3) nv = 3'd1;
            if (p == 1) nv = 3'd4;
            en = (nv == 0) ? 1 : ((nv > 4) ? 4 : nv);
            counts = $urandom;
            mask   = 4'($urandom_range(0, 15));
            fixl   = $urandom;
            prod   = 1;
            for (int v = 0; v < en; v++) begin
                c = 8'($urandom_range(1, (en <= 2) ? 6 : 3));
                if (p == 2) c = 8'd0;
                if (p == 3) c = 8'd255;
                counts[8*v +: 8] = c;
                if ($urandom_range(0, 4) != 0)
                    fixl[8*v +: 8] = 8'($urandom_range(0, (c == 0) ? 255 : c - 1));
                prod = prod * ((c == 0) ? 256 : c);
            end
            load_regs(nv, counts, mask, fixl);
            sent = 0;
            while (sent < 48) begin
                len = prod;
                if ($urandom_range(0, 6) == 0) len = $urandom_range(1, prod + 3);
                send_table(len);
                sent += len;
                if (p == 5 && sent < 48) settle();
            end
            settle();
        end

        if (mismatches == 0)
            $display("restricted_factor_argmin_core test passed");
        else
            $display("restricted_factor_argmin_core test failed");
        $finish;
    end

endmodule
